FILE: design/modular_exponentiation_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular exponentiation core
// Shared property wrappers, clocked on the rising edge and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_MACROS_SVH
`define MODULAR_EXPONENTIATION_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Sequencer state codes and the status group of the modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Status of the shared modular multiplier.
    typedef struct packed {
        logic busy;
        logic done;
    } mexp_mm_status_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_SCAN = 6'b000100,
        S_SQR  = 6'b001000,
        S_MUL  = 6'b010000,
        S_DONE = 6'b100000
    } mexp_state_t;

endpackage

FILE: design/mexp_modmul.sv
// ----------------------------------------------------------------------------
// Modular multiplier
// Shift-and-add multiplier that keeps the accumulator reduced, one modular
// addition per cycle: a doubling for every multiplier bit, then an add of the
// multiplicand when that bit is set. Requires x below the modulus.
// ----------------------------------------------------------------------------
module mexp_modmul
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WIDTH-1:0]     x,
    input  logic [WIDTH-1:0]     y,
    input  logic [WIDTH-1:0]     modulus,
    output logic [WIDTH-1:0]     product,
    output mexp_mm_status_t      status
);

    localparam int CW = $clog2(WIDTH);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic               phase_reg, phase_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [WIDTH-1:0]   acc_reg, acc_next;
    logic [WIDTH-1:0]   x_reg, x_next;
    logic [WIDTH-1:0]   y_reg, y_next;

    logic [WIDTH-1:0]   addend;
    logic [WIDTH:0]     sum;
    logic [WIDTH+1:0]   diff;
    logic [WIDTH-1:0]   sum_mod;

    // Both operands are below the modulus, so one conditional subtract reduces.
    assign addend  = phase_reg ? x_reg : acc_reg;
    assign sum     = {1'b0, acc_reg} + {1'b0, addend};
    assign diff    = {1'b0, sum} - {2'b00, modulus};
    assign sum_mod = diff[WIDTH+1] ? sum[WIDTH-1:0] : diff[WIDTH-1:0];

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        if (!busy_reg)
        begin
            if (start)
            begin
                busy_next  = 1'b1;
                phase_next = 1'b0;
                cnt_next   = CW'(WIDTH - 1);
                acc_next   = '0;
                x_next     = x;
                y_next     = y;
            end
        end
        else
        begin
            acc_next = sum_mod;
            if (!phase_reg && y_reg[WIDTH-1])
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                y_next     = y_reg << 1;
                if (cnt_reg == '0)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

FILE: design/modular_exponentiation_core.sv
// Sequence: for a zero exponent or a modulus below 2 the accepted item goes through
// S_DONE to the output register. Otherwise each modular product takes a doubling per
// multiplier bit and an add per set bit; an item needs one base reduction, a scan over
// the leading zeros and one or two products per exponent bit below the leading one.
// Throughput: one item at a time, bounded by the single shared modular adder.
// Reset: asynchronous and active low; the modulus returns to 2, the block to idle.
// ----------------------------------------------------------------------------
// Modular exponentiation core
// Left-to-right square-and-multiply over a configured modulus, sequenced
// around one shift-and-add modular multiplier.
// ----------------------------------------------------------------------------
`include "modular_exponentiation_core_macros.svh"

module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [WIDTH-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] base_value,
    input  logic [WIDTH-1:0] exponent,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] power_result
);

    localparam int CW = $clog2(WIDTH);

    mexp_state_t        state_reg, state_next;
    logic [WIDTH-1:0]   modulus_reg;
    logic [WIDTH-1:0]   exp_reg, exp_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [WIDTH-1:0]   bm_reg, bm_next;
    logic [WIDTH-1:0]   r_reg, r_next;
    logic               out_valid_reg, out_valid_next;
    logic [WIDTH-1:0]   result_reg, result_next;

    logic               mm_start;
    logic [WIDTH-1:0]   mm_x;
    logic [WIDTH-1:0]   mm_y;
    logic [WIDTH-1:0]   mm_product;
    mexp_mm_status_t    mm_status;

    mexp_modmul #(
        .WIDTH (WIDTH)
    ) u_modmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .x       (mm_x),
        .y       (mm_y),
        .modulus (modulus_reg),
        .product (mm_product),
        .status  (mm_status)
    );

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        logic             adv;
        logic [WIDTH-1:0] adv_val;

        adv            = 1'b0;
        adv_val        = mm_product;
        state_next     = state_reg;
        exp_next       = exp_reg;
        cnt_next       = cnt_reg;
        bm_next        = bm_reg;
        r_next         = r_reg;
        mm_start       = 1'b0;
        mm_x           = bm_reg;
        mm_y           = bm_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    exp_next = exponent;
                    cnt_next = CW'(WIDTH - 1);
                    if (exponent == '0)
                    begin
                        r_next     = WIDTH'(1);
                        state_next = S_DONE;
                    end
                    else if (modulus_reg < WIDTH'(2))
                    begin
                        r_next     = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Base reduction: 1 * base through the same multiplier.
                        mm_start   = 1'b1;
                        mm_x       = WIDTH'(1);
                        mm_y       = base_value;
                        state_next = S_RED;
                    end
                end
            end
            S_RED:
            begin
                if (mm_status.done)
                begin
                    bm_next    = mm_product;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Skip leading zeros; cnt_reg counts the bits below the current one.
                exp_next = exp_reg << 1;
                if (exp_reg[WIDTH-1])
                begin
                    if (cnt_reg == '0)
                    begin
                        r_next     = bm_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mm_start   = 1'b1;
                        mm_x       = bm_reg;
                        mm_y       = bm_reg;
                        state_next = S_SQR;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_SQR:
            begin
                if (mm_status.done)
                begin
                    if (exp_reg[WIDTH-1])
                    begin
                        mm_start   = 1'b1;
                        mm_x       = mm_product;
                        mm_y       = bm_reg;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        adv = 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                if (mm_status.done)
                begin
                    adv = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    result_next    = r_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // One exponent bit is finished: move to the next or hand off the result.
        if (adv)
        begin
            exp_next = exp_reg << 1;
            if (cnt_reg == CW'(1))
            begin
                r_next     = adv_val;
                state_next = S_DONE;
            end
            else
            begin
                cnt_next   = cnt_reg - CW'(1);
                mm_start   = 1'b1;
                mm_x       = adv_val;
                mm_y       = adv_val;
                state_next = S_SQR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            modulus_reg   <= WIDTH'(2);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                modulus_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        cnt_reg    <= cnt_next;
        bm_reg     <= bm_next;
        r_reg      <= r_next;
        result_reg <= result_next;
    end

    assign out_valid    = out_valid_reg;
    assign power_result = result_reg;

    `MEXP_ASSERT_SAME(a_start_when_free, clk, rst_n, mm_start, !mm_status.busy)
    `MEXP_ASSERT_SAME(a_product_reduced, clk, rst_n, mm_status.done, mm_product < modulus_reg)
    `MEXP_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_reg != S_IDLE)
    `MEXP_ASSERT_NEXT(a_done_loads_output, clk, rst_n, state_reg == S_DONE && !out_valid_reg,
                      out_valid_reg && state_reg == S_IDLE)

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modular exponentiation core testbench
// Feeds base and exponent beats through a queue-fed driver under random
// idling and one long output stall. Each result is checked against a local
// square-and-multiply predictor that tracks the programmed modulus.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int W            = 32;
    localparam int CLK_HALF     = 4;
    localparam int SETTLE_TICKS = 2 * (2 * W + 1) + 8;
    localparam int STALL_TICKS  = 1500;
    localparam int CYCLE_LIMIT  = 5_000_000;

    typedef struct {
        logic [W-1:0] base;
        logic [W-1:0] power;
    } operand_t;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         cfg_we       = 1'b0;
    logic [W-1:0] cfg_wdata    = '0;
    logic         in_valid     = 1'b0;
    logic         in_ready;
    logic [W-1:0] base_value   = '0;
    logic [W-1:0] exponent     = '0;
    logic         out_valid;
    logic         out_ready    = 1'b0;
    logic [W-1:0] power_result;

    operand_t     operand_q[$];
    logic [W-1:0] power_q[$];
    logic [W-1:0] modulus_model = 2;

    logic         in_taken     = 1'b0;
    logic         out_taken    = 1'b0;
    int           send_wait    = 0;
    int           recv_wait    = 0;
    bit           send_calm    = 1'b0;
    bit           recv_calm    = 1'b0;
    bit           stall_req    = 1'b0;
    bit           stall_done   = 1'b0;
    int           stall_left   = 0;
    int           fault_count  = 0;
    int           cycle_count  = 0;

    modular_exponentiation_core #(
        .WIDTH(W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .base_value  (base_value),
        .exponent    (exponent),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .power_result(power_result)
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Right-to-left square-and-multiply; every product fits in double width.
    function automatic logic [W-1:0] predict_power(logic [W-1:0] b, logic [W-1:0] e,
                                                   logic [W-1:0] m);
        logic [2*W-1:0] acc;
        logic [2*W-1:0] sq;
        if (e == 0)
            return 1;
        if (m <= 1)
            return 0;
        acc = 1;
        sq  = b % m;
        for (int i = 0; i < W; i++)
        begin
            if (e[i])
                acc = (acc * sq) % m;
            sq = (sq * sq) % m;
        end
        return acc[W-1:0];
    endfunction

    function automatic int draw_wait(bit calm);
        if (calm)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic logic [W-1:0] rand_base(logic [W-1:0] m);
        logic [W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1:    v = $urandom;
            2:       v = $urandom_range(0, 3);
            3:       v = m - 1 - $urandom_range(0, 3);
            4:       v = m + $urandom_range(0, 3);
            default: v = (m > 1) ? $urandom % m : $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [W-1:0] rand_exp();
        logic [W-1:0] v;
        int           k;
        case ($urandom_range(0, 4))
            0, 1:    v = $urandom;
            2:
            begin
                k = $urandom_range(1, W);
                v = $urandom >> (W - k);
                v[k-1] = 1'b1;
            end
            3:       v = $urandom_range(0, 15);
            default: v = {W{1'b1}} ^ $urandom_range(0, 3);
        endcase
        return v;
    endfunction

    task automatic add_operands(logic [W-1:0] b, logic [W-1:0] e);
        operand_t op;
        op.base  = b;
        op.power = e;
        operand_q.insert(operand_q.size(), op);
    endtask

    // Waits until every queued beat has been sent and answered, then lets
    // the core go quiet before the modulus may change. The check runs at the
    // rising edge so the driver's falling-edge updates are already visible.
    task automatic settle();
        @(posedge clk);
        while (operand_q.size() != 0 || in_valid || power_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(negedge clk);
    endtask

    task automatic write_modulus(logic [W-1:0] m);
        settle();
        @(negedge clk);
        cfg_we        <= 1'b1;
        cfg_wdata     <= m;
        modulus_model  = m;
        @(negedge clk);
        cfg_we        <= 1'b0;
    endtask

    task automatic run_random(logic [W-1:0] m, int count);
        write_modulus(m);
        repeat (count) add_operands(rand_base(m), rand_exp());
    endtask

    // Input driver: a new beat is presented once the previous one has been
    // taken and its drawn gap has elapsed.
    always @(negedge clk)
    begin : drive_in
        logic     nxt_valid;
        operand_t op;
        nxt_valid = in_valid;
        if (in_valid && in_taken)
        begin
            nxt_valid = 1'b0;
            send_wait = draw_wait(send_calm);
        end
        if (!nxt_valid && rst_n)
        begin
            if (send_wait > 0)
                send_wait--;
            else if (operand_q.size() != 0)
            begin
                op          = operand_q.pop_front();
                base_value <= op.base;
                exponent   <= op.power;
                nxt_valid   = 1'b1;
            end
        end
        in_valid <= nxt_valid;
    end

    always @(negedge clk)
    begin : drive_out
        if (out_taken)
            recv_wait = draw_wait(recv_calm);
        if (!rst_n || stall_left != 0)
            out_ready <= 1'b0;
        else if (recv_wait > 0)
        begin
            recv_wait--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // One long hold-off on the result side so the core backs up its input.
    always @(posedge clk)
    begin : hold_receiver
        if (stall_req && !stall_done)
        begin
            stall_left <= STALL_TICKS;
            stall_done <= 1'b1;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    always @(posedge clk)
    begin : watch_ports
        logic [W-1:0] want;
        in_taken  <= rst_n && in_valid && in_ready;
        out_taken <= rst_n && out_valid && out_ready;
        // The result side is checked before the new beat is queued, so a
        // result can never be matched to the beat taken at the same edge.
        if (rst_n && out_valid && out_ready)
        begin
            if (power_q.size() == 0)
            begin
                if (fault_count < 10)
                    $display("unexpected result beat: power_result=%h", power_result);
                fault_count++;
            end
            else
            begin
                want = power_q.pop_front();
                if (power_result !== want)
                begin
                    if (fault_count < 10)
                        $display("power_result mismatch: expected %h, actual %h",
                                 want, power_result);
                    fault_count++;
                end
            end
        end
        if (rst_n && in_valid && in_ready)
            power_q.insert(power_q.size(),
                           predict_power(base_value, exponent, modulus_model));
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Modulus left at its reset value of two.
        add_operands('0, '0);
        add_operands('1, '1);
        add_operands(3, 0);
        add_operands(5, 3);
        add_operands(4, 1);

        write_modulus('1);
        add_operands(0, 1);
        add_operands('1, 5);
        add_operands('1 - 1, 2);
        add_operands(2, '1);
        add_operands(32'h1234_5678, 32'h8000_0000);
        add_operands(1, 0);
        repeat (40) add_operands(rand_base('1), rand_exp());

        // A zero modulus gives zero for any nonzero exponent.
        write_modulus(0);
        add_operands(7, 0);
        add_operands(7, 1);
        add_operands('1, '1);
        repeat (10) add_operands(rand_base(0), rand_exp());

        write_modulus(1);
        add_operands(9, 0);
        add_operands(9, 2);
        add_operands('1, '1);
        repeat (10) add_operands(rand_base(1), rand_exp());

        write_modulus(3);
        add_operands(5, 2);
        add_operands(2, '1);
        add_operands(3, 7);
        repeat (20) add_operands(rand_base(3), rand_exp());

        run_random(32'hFFFF_FFFB, 60);

        // No idling on either side for this stretch.
        settle();
        send_calm = 1'b1;
        recv_calm = 1'b1;
        run_random(32'h8000_0000, 30);

        // The sender keeps offering short jobs while the result side stalls.
        write_modulus($urandom | 32'h0000_0100);
        recv_calm = 1'b0;
        stall_req = 1'b1;
        repeat (20) add_operands(rand_base(modulus_model), $urandom_range(1, 15));
        settle();
        send_calm = 1'b0;

        run_random($urandom_range(2, 255), 25);
        run_random($urandom, 25);
        run_random($urandom | 32'h8000_0001, 25);
        run_random($urandom, 25);

        settle();
        if (fault_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
